// ===== rtl/priority_ready_list_manager_assert.svh =====
// Assertion macros for the ready-list manager.
`ifndef PRIORITY_READY_LIST_MANAGER_ASSERT_SVH
`define PRIORITY_READY_LIST_MANAGER_ASSERT_SVH

// Consequent checked on the same edge.
`define PRLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked a fixed number of edges later.
`define PRLM_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== rtl/prlm_pkg.sv =====
`timescale 1ns / 1ps
package prlm_pkg;

  typedef enum logic [2:0] {
    OP_INS_AUTO = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_ROTATE   = 3'd3,
    OP_REMOVE   = 3'd4
  } op_t;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_SLOT_W  = 5;
  localparam int OUT_BM_W    = 32;

endpackage

// ===== rtl/priority_ready_list_manager.sv =====
`timescale 1ns / 1ps
`include "priority_ready_list_manager_assert.svh"
// Channel | Dir | Beat contents (lowest bit up)
// in_     | in  | operation[2:0] task_id[6:3] task_prio[11:7] current_prio[16:12]
// out_    | out | head_task[4:0] tail_task[9:5] entry_count[14:10] ready_bitmap[46:15]
//
// Beat accepted, then root and link read, head link read, then three link-memory
// write slots on a single write port; the result is registered at the end of the
// final write step. A new beat is taken only once the last result is registered;
// a stalled result holds the final write step. Sync active-low reset empties all
// lists and the bitmap at once via per-level valid bits; link entries are not cleared.
module priority_ready_list_manager #(
  parameter int NUM_TASKS   = 16,
  parameter int PRIO_LEVELS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // operation, task_id, task_prio, current_prio
  input  logic [prlm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // head_task, tail_task, entry_count, ready_bitmap
  output logic [prlm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int SW = $clog2(NUM_TASKS + 1);
  localparam int AW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(PRIO_LEVELS);
  localparam logic [SW-1:0] NONE = SW'(NUM_TASKS);

  typedef enum logic [2:0] {S_IDLE, S_ROOT, S_HEAD, S_WR1, S_WR2} state_t;

  typedef struct packed {
    logic          en;
    logic [SW-1:0] slot;
    logic          wn;
    logic          wp;
    logic [SW-1:0] nv;
    logic [SW-1:0] pv;
  } lwr_t;

  function automatic lwr_t mk_wr(input logic [SW-1:0] slot, input logic wn,
                                 input logic wp, input logic [SW-1:0] nv,
                                 input logic [SW-1:0] pv);
    lwr_t w;
    w.en   = slot < NONE;
    w.slot = slot;
    w.wn   = wn;
    w.wp   = wp;
    w.nv   = nv;
    w.pv   = pv;
    return w;
  endfunction

  state_t            state_r;
  prlm_pkg::op_t     op_r;
  logic [SW-1:0]     tid_r;
  logic [LW-1:0]     lvl_r;
  logic              prio_ok_r;
  logic              task_ok_r;
  logic              same_r;
  logic [SW-1:0]     tn_r;
  logic [SW-1:0]     tp_r;
  lwr_t              wr1_r;
  lwr_t              wr2_r;
  logic [PRIO_LEVELS-1:0] bm_r;
  logic [SW-1:0]     res_head_r;
  logic [SW-1:0]     res_tail_r;
  logic [SW-1:0]     res_cnt_r;
  logic              out_valid_r;
  logic [prlm_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [3:0]        in_tid;
  logic [4:0]        in_prio;
  logic [4:0]        in_cur;
  logic [SW-1:0]     in_slot;
  logic [LW-1:0]     in_lvl;
  logic              in_task_ok;
  logic              in_prio_ok;
  logic              accept;
  logic              out_free;

  logic              lk_rd_en;
  logic [AW-1:0]     lk_rd_addr;
  logic [SW-1:0]     lk_rd_next;
  logic [SW-1:0]     lk_rd_prev;
  lwr_t              lk_wr;

  logic [SW-1:0]     rt_head;
  logic [SW-1:0]     rt_tail;
  logic [SW-1:0]     rt_cnt;

  logic [SW-1:0]     hn;
  lwr_t              wr0_nxt;
  lwr_t              wr1_nxt;
  lwr_t              wr2_nxt;
  logic [SW-1:0]     head_nxt;
  logic [SW-1:0]     tail_nxt;
  logic [SW-1:0]     cnt_nxt;
  logic              root_we;
  logic [PRIO_LEVELS-1:0] bm_nxt;
  logic [SW-1:0]     cnt_inc;
  logic [SW-1:0]     cnt_dec;

  assign in_tid     = in_tdata[6:3];
  assign in_prio    = in_tdata[11:7];
  assign in_cur     = in_tdata[16:12];
  assign in_slot    = SW'(in_tid);
  assign in_lvl     = LW'(in_prio);
  assign in_task_ok = int'(in_tid) < NUM_TASKS;
  assign in_prio_ok = int'(in_prio) < PRIO_LEVELS;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign lk_rd_en   = accept || (state_r == S_ROOT);
  assign lk_rd_addr = accept ? in_slot[AW-1:0] : rt_head[AW-1:0];

  always_comb begin
    case (state_r)
      S_HEAD:  lk_wr = wr0_nxt;
      S_WR1:   lk_wr = wr1_r;
      S_WR2:   lk_wr = wr2_r;
      default: lk_wr = '0;
    endcase
  end

  prlm_link_mem #(
    .NUM_TASKS (NUM_TASKS),
    .SW        (SW),
    .AW        (AW)
  ) u_link (
    .clk        (clk),
    .rd_en      (lk_rd_en),
    .rd_addr    (lk_rd_addr),
    .rd_next    (lk_rd_next),
    .rd_prev    (lk_rd_prev),
    .wr_en      (lk_wr.en),
    .wr_addr    (lk_wr.slot[AW-1:0]),
    .wr_next_en (lk_wr.wn),
    .wr_prev_en (lk_wr.wp),
    .wr_next    (lk_wr.nv),
    .wr_prev    (lk_wr.pv)
  );

  prlm_root_mem #(
    .NUM_TASKS (NUM_TASKS),
    .LEVELS    (PRIO_LEVELS),
    .SW        (SW),
    .LW        (LW)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_lvl),
    .rd_head  (rt_head),
    .rd_tail  (rt_tail),
    .rd_count (rt_cnt),
    .wr_en    (root_we),
    .wr_addr  (lvl_r),
    .wr_head  (head_nxt),
    .wr_tail  (tail_nxt),
    .wr_count (cnt_nxt)
  );

  assign hn      = (rt_head < NONE) ? lk_rd_next : NONE;
  assign cnt_inc = (rt_cnt < NONE) ? rt_cnt + SW'(1) : rt_cnt;
  assign cnt_dec = (rt_cnt != '0) ? rt_cnt - SW'(1) : rt_cnt;

  // list update, evaluated in the head step
  always_comb begin
    wr0_nxt  = '0;
    wr1_nxt  = '0;
    wr2_nxt  = '0;
    head_nxt = rt_head;
    tail_nxt = rt_tail;
    cnt_nxt  = rt_cnt;
    root_we  = 1'b0;
    bm_nxt   = bm_r;
    if (prio_ok_r) begin
      case (op_r)
        prlm_pkg::OP_INS_AUTO, prlm_pkg::OP_INS_HEAD, prlm_pkg::OP_INS_TAIL: begin
          if (task_ok_r) begin
            bm_nxt[lvl_r] = 1'b1;
            root_we       = 1'b1;
            if (rt_cnt == '0) begin
              wr0_nxt  = mk_wr(tid_r, 1'b1, 1'b1, NONE, NONE);
              head_nxt = tid_r;
              tail_nxt = tid_r;
              cnt_nxt  = SW'(1);
            end else if (op_r == prlm_pkg::OP_INS_HEAD ||
                         (op_r == prlm_pkg::OP_INS_AUTO && !same_r)) begin
              cnt_nxt  = cnt_inc;
              wr0_nxt  = mk_wr(tid_r, 1'b1, 1'b1, rt_head, NONE);
              wr1_nxt  = mk_wr(rt_head, 1'b0, 1'b1, '0, tid_r);
              head_nxt = tid_r;
            end else begin
              cnt_nxt  = cnt_inc;
              wr0_nxt  = mk_wr(tid_r, 1'b1, 1'b1, NONE, rt_tail);
              wr1_nxt  = mk_wr(rt_tail, 1'b1, 1'b0, tid_r, '0);
              tail_nxt = tid_r;
            end
          end
        end
        prlm_pkg::OP_ROTATE: begin
          if (rt_cnt == SW'(2)) begin
            root_we  = 1'b1;
            wr0_nxt  = mk_wr(rt_head, 1'b1, 1'b1, NONE, rt_tail);
            wr1_nxt  = mk_wr(rt_tail, 1'b1, 1'b1, rt_head, NONE);
            head_nxt = rt_tail;
            tail_nxt = rt_head;
          end else if (rt_cnt > SW'(2)) begin
            root_we  = 1'b1;
            wr0_nxt  = mk_wr(hn, 1'b0, 1'b1, '0, NONE);
            wr1_nxt  = mk_wr(rt_head, 1'b1, 1'b1, NONE, rt_tail);
            wr2_nxt  = mk_wr(rt_tail, 1'b1, 1'b0, rt_head, '0);
            head_nxt = hn;
            tail_nxt = rt_head;
          end
        end
        prlm_pkg::OP_REMOVE: begin
          if (task_ok_r) begin
            root_we = 1'b1;
            if (tp_r == NONE) begin
              if (tn_r == NONE) begin
                head_nxt      = NONE;
                tail_nxt      = NONE;
                cnt_nxt       = '0;
                bm_nxt[lvl_r] = 1'b0;
                wr0_nxt       = mk_wr(tid_r, 1'b1, 1'b1, NONE, NONE);
              end else begin
                cnt_nxt  = cnt_dec;
                wr0_nxt  = mk_wr(tn_r, 1'b0, 1'b1, '0, NONE);
                wr1_nxt  = mk_wr(tid_r, 1'b1, 1'b1, NONE, NONE);
                head_nxt = tn_r;
              end
            end else begin
              cnt_nxt = cnt_dec;
              wr0_nxt = mk_wr(tp_r, 1'b1, 1'b0, tn_r, '0);
              if (tn_r == NONE) begin
                tail_nxt = tp_r;
              end else begin
                wr1_nxt = mk_wr(tn_r, 1'b0, 1'b1, '0, tp_r);
              end
              wr2_nxt = mk_wr(tid_r, 1'b1, 1'b1, NONE, NONE);
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r != S_HEAD) begin
      root_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bm_r        <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_WR2) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r   <= S_ROOT;
            op_r      <= prlm_pkg::op_t'(in_tdata[2:0]);
            tid_r     <= in_slot;
            lvl_r     <= in_lvl;
            prio_ok_r <= in_prio_ok;
            task_ok_r <= in_task_ok;
            same_r    <= (in_prio == in_cur);
          end
        end
        S_ROOT: begin
          state_r <= S_HEAD;
          tn_r    <= lk_rd_next;
          tp_r    <= lk_rd_prev;
        end
        S_HEAD: begin
          state_r <= S_WR1;
          wr1_r   <= wr1_nxt;
          wr2_r   <= wr2_nxt;
          bm_r    <= bm_nxt;
          if (prio_ok_r) begin
            res_head_r <= head_nxt;
            res_tail_r <= tail_nxt;
            res_cnt_r  <= cnt_nxt;
          end else begin
            res_head_r <= NONE;
            res_tail_r <= NONE;
            res_cnt_r  <= '0;
          end
        end
        S_WR1: begin
          state_r <= S_WR2;
        end
        S_WR2: begin
          if (out_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, prlm_pkg::OUT_BM_W'(bm_r),
                            prlm_pkg::OUT_SLOT_W'(res_cnt_r),
                            prlm_pkg::OUT_SLOT_W'(res_tail_r),
                            prlm_pkg::OUT_SLOT_W'(res_head_r)};
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `PRLM_ASSERT_DELAY(a_seq_len, in_tvalid && in_tready, 4, state_r == S_WR2, "item missed final write step")
  `PRLM_ASSERT_SAME(a_out_src, $rose(out_tvalid), $past(state_r) == S_WR2, "result raised outside final step")
  `PRLM_ASSERT_SAME(a_root_src, state_r == S_ROOT, $past(in_tvalid && in_tready), "lookup without an accepted beat")

endmodule

// ===== rtl/prlm_link_mem.sv =====
`timescale 1ns / 1ps
module prlm_link_mem #(
  parameter int NUM_TASKS = 16,
  parameter int SW        = 5,
  parameter int AW        = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [SW-1:0] rd_next,
  output logic [SW-1:0] rd_prev,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_next_en,
  input  logic          wr_prev_en,
  input  logic [SW-1:0] wr_next,
  input  logic [SW-1:0] wr_prev
);

  logic [SW-1:0] next_mem [NUM_TASKS];
  logic [SW-1:0] prev_mem [NUM_TASKS];
  logic [SW-1:0] rd_next_r;
  logic [SW-1:0] rd_prev_r;

  always_ff @(posedge clk) begin
    if (wr_en && wr_next_en) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (wr_en && wr_prev_en) begin
      prev_mem[wr_addr] <= wr_prev;
    end
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
    end
  end

  assign rd_next = rd_next_r;
  assign rd_prev = rd_prev_r;

endmodule

// ===== rtl/prlm_root_mem.sv =====
`timescale 1ns / 1ps
module prlm_root_mem #(
  parameter int NUM_TASKS = 16,
  parameter int LEVELS    = 32,
  parameter int SW        = 5,
  parameter int LW        = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [LW-1:0] rd_addr,
  output logic [SW-1:0] rd_head,
  output logic [SW-1:0] rd_tail,
  output logic [SW-1:0] rd_count,
  input  logic          wr_en,
  input  logic [LW-1:0] wr_addr,
  input  logic [SW-1:0] wr_head,
  input  logic [SW-1:0] wr_tail,
  input  logic [SW-1:0] wr_count
);

  localparam logic [SW-1:0] NONE = SW'(NUM_TASKS);

  logic [3*SW-1:0] mem [LEVELS];
  logic [LEVELS-1:0] vld_r;
  logic [3*SW-1:0] rd_data_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_tail, wr_count};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // unwritten levels read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_head  = rd_vld_r ? rd_data_r[3*SW-1:2*SW] : NONE;
  assign rd_tail  = rd_vld_r ? rd_data_r[2*SW-1:SW]   : NONE;
  assign rd_count = rd_vld_r ? rd_data_r[SW-1:0]      : '0;

endmodule
